/* rtl/pure_pursuit_steering_speed_assert.svh */
// assertion macros shared by the checker
`ifndef PURE_PURSUIT_STEERING_SPEED_ASSERT_SVH
`define PURE_PURSUIT_STEERING_SPEED_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define PPSS_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while in reset
`define PPSS_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

// what must hold in the cycle after reset is sampled
`define PPSS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

/* rtl/ppss_pkg.sv */
`timescale 1ns / 1ps
package ppss_pkg;

  localparam int unsigned CoefW       = 32;
  localparam int unsigned HornerSteps = 3;
  localparam int unsigned YW          = 48;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CxW         = 34;
  localparam int unsigned CzW         = 33;
  localparam int unsigned RatioW      = 30;

  // offset clamp, 2^46 in Q.24
  localparam logic signed [YW-1:0] YLimit = 48'sd70368744177664;
  // 64*2160/pi in Q16
  localparam logic [31:0] DegScale = 32'd2883791006;
  localparam logic signed [15:0] AngleMax = 16'sd30720;
  localparam logic signed [15:0] AngleMin = -16'sd31360;

  // arctan(2^-i) in Q2.30 radians
  localparam logic [31:0] AtanQ30 [CordicSteps] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  typedef enum logic [2:0] {
    REG_LOOKAHEAD    = 3'd0,
    REG_WHEELBASE    = 3'd1,
    REG_SPEED_GAIN   = 3'd2,
    REG_MODE         = 3'd3,
    REG_LANE_MAX     = 3'd4,
    REG_WAYPOINT_MAX = 3'd5,
    REG_FLOOR        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] look_dist;
    logic [15:0] wheelbase_len;
    logic [23:0] speed_gain;
    logic        mode_select;
    logic [7:0]  lane_max_speed;
    logic [7:0]  wpt_max_speed;
    logic [7:0]  floor_speed;
  } cfg_t;

  typedef struct packed {
    logic [RatioW-1:0] num;
    logic [RatioW-1:0] den;
    logic              neg;
    logic              go;
  } ratio_t;

  typedef struct packed {
    logic signed [CzW-1:0] z;
    logic                  neg;
    logic                  go;
  } angle_t;

  // position of the highest set bit plus one, zero for zero
  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

/* rtl/pure_pursuit_steering_speed.sv */
`timescale 1ns / 1ps
// pure pursuit steering and speed command
// in_*  : one lane cubic per word, four signed Q7.24 coefficients
// out_* : one result word per input word, wheel angle Q10.6 degrees and
//         speed command Q8.8, in input order
// cfg_* : register writes, taken on any cycle cfg_we is high; write only
//         while no word is in flight
// pipeline: 49 register stages (6 Horner, 7 ratio and normalize,
//   30 CORDIC rotation stages, 6 degree scaling and speed stages);
//   the first loads at the edge that accepts an input word, and the
//   valid bit of the last one drives out_tvalid
// throughput: one word per cycle; every stage carries a valid bit and
//   loads whenever it is empty or the stage after it moves, so bubbles
//   close up and input keeps flowing while a finished result waits
// receiver stall: words pile up stage by stage, in_tready drops only once
//   the whole pipeline is full; nothing is lost or repeated
// reset: synchronous, active low; clears all valid bits and loads the
//   register defaults
module pure_pursuit_steering_speed (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_const, coef_linear, coef_square, coef_cube (32 bits each)
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // wheel_angle (16), speed_cmd (16)
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import ppss_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  logic               h_valid, h_ready;
  logic signed [YW-1:0] h_y;
  logic               r_valid, r_ready;
  ratio_t             r_ratio;
  logic               c_valid, c_ready;
  angle_t             c_angle;
  logic signed [15:0] wheel_angle;
  logic [15:0]        speed_cmd;

  // register file, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOOKAHEAD:    cfg_nxt.look_dist          = cfg_data[15:0];
        REG_WHEELBASE:    cfg_nxt.wheelbase_len      = cfg_data[15:0];
        REG_SPEED_GAIN:   cfg_nxt.speed_gain         = cfg_data;
        REG_MODE:         cfg_nxt.mode_select        = cfg_data[0];
        REG_LANE_MAX:     cfg_nxt.lane_max_speed     = cfg_data[7:0];
        REG_WAYPOINT_MAX: cfg_nxt.wpt_max_speed      = cfg_data[7:0];
        REG_FLOOR:        cfg_nxt.floor_speed        = cfg_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.look_dist          <= 16'd1536;
      cfg_r.wheelbase_len      <= 16'd768;
      cfg_r.speed_gain         <= 24'd25166;
      cfg_r.mode_select        <= 1'b0;
      cfg_r.lane_max_speed     <= 8'd20;
      cfg_r.wpt_max_speed      <= 8'd20;
      cfg_r.floor_speed        <= 8'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // goal lateral offset at the lookahead distance
  ppss_horner u_horner (
    .clk         (clk),
    .rst_n       (rst_n),
    .look_dist   (cfg_r.look_dist),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .coef_const  ($signed(in_tdata[31:0])),
    .coef_linear ($signed(in_tdata[63:32])),
    .coef_square ($signed(in_tdata[95:64])),
    .coef_cube   ($signed(in_tdata[127:96])),
    .out_valid   (h_valid),
    .out_ready   (h_ready),
    .offset_y    (h_y)
  );

  // curvature ratio operands, normalized to 30 bits
  ppss_ratio u_ratio (
    .clk           (clk),
    .rst_n         (rst_n),
    .look_dist     (cfg_r.look_dist),
    .wheelbase_len (cfg_r.wheelbase_len),
    .in_valid      (h_valid),
    .in_ready      (h_ready),
    .offset_y      (h_y),
    .out_valid     (r_valid),
    .out_ready     (r_ready),
    .ratio         (r_ratio)
  );

  // arctangent, one rotation per stage
  ppss_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .ratio     (r_ratio),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .angle     (c_angle)
  );

  // wheel degrees, clamp, speed penalty; last stage is the output register
  ppss_post u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (c_valid),
    .in_ready     (c_ready),
    .angle        (c_angle),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .wheel_angle  (wheel_angle),
    .speed_cmd    (speed_cmd)
  );

  assign out_tdata = {speed_cmd, wheel_angle};

endmodule

/* rtl/ppss_horner.sv */
`timescale 1ns / 1ps
module ppss_horner (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [15:0]                        look_dist,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ppss_pkg::CoefW-1:0]  coef_const,
  input  logic signed [ppss_pkg::CoefW-1:0]  coef_linear,
  input  logic signed [ppss_pkg::CoefW-1:0]  coef_square,
  input  logic signed [ppss_pkg::CoefW-1:0]  coef_cube,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ppss_pkg::YW-1:0]     offset_y
);
  import ppss_pkg::*;

  localparam int unsigned NS    = 2 * HornerSteps;
  localparam int unsigned MagW  = YW - 1;
  localparam int unsigned ProdW = MagW + 16;
  localparam int unsigned SumW  = ProdW - 5;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  // coefficients ride along: 0 const, 1 linear, 2 square
  logic signed [CoefW-1:0] co_r [NS-1][HornerSteps];
  logic [ProdW-1:0]        prod_r [HornerSteps];
  logic                    neg_r  [HornerSteps];
  logic signed [YW-1:0]    y_r    [HornerSteps];

  assign adv[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      co_r[0][0] <= coef_const;
      co_r[0][1] <= coef_linear;
      co_r[0][2] <= coef_square;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (adv[k]) co_r[k] <= co_r[k-1];
    end
  end

  for (genvar j = 0; j < HornerSteps; j++) begin : g_step
    logic signed [YW-1:0]   y_src;
    logic [MagW-1:0]        y_mag;
    logic [ProdW:0]         rnd;
    logic [ProdW-8:0]       m;
    logic signed [SumW-1:0] t;
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] sat;

    if (j == 0) begin : g_first
      assign y_src = YW'(coef_cube);
    end else begin : g_next
      assign y_src = y_r[j-1];
    end

    assign y_mag = y_src[YW-1] ? MagW'(-y_src) : MagW'(y_src);

    // multiply by x
    always_ff @(posedge clk) begin
      if (adv[2*j]) begin
        prod_r[j] <= ProdW'(y_mag) * ProdW'(look_dist);
        neg_r[j]  <= y_src[YW-1];
      end
    end

    // round off 8 bits, restore sign, add coefficient, clamp
    always_comb begin
      rnd = {1'b0, prod_r[j]} + (ProdW+1)'(128);
      m   = rnd[ProdW:8];
      t   = neg_r[j] ? -SumW'($signed({1'b0, m})) : SumW'($signed({1'b0, m}));
      sum = t + SumW'(co_r[2*j][2-j]);
      if (sum > SumW'(YLimit))       sat = SumW'(YLimit);
      else if (sum < -SumW'(YLimit)) sat = -SumW'(YLimit);
      else                           sat = sum;
    end

    always_ff @(posedge clk) begin
      if (adv[2*j+1]) y_r[j] <= YW'(sat);
    end
  end

  assign out_valid = v_r[NS-1];
  assign offset_y  = y_r[HornerSteps-1];

endmodule

/* rtl/ppss_ratio.sv */
`timescale 1ns / 1ps
module ppss_ratio (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [15:0]                    look_dist,
  input  logic [15:0]                    wheelbase_len,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ppss_pkg::YW-1:0] offset_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppss_pkg::ratio_t               ratio
);
  import ppss_pkg::*;

  localparam int unsigned NS = 7;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  logic        neg0_r, neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [31:0] bx0_r, bx1_r;
  logic [46:0] by0_r, by1_r;
  logic [4:0]  s1_r;
  logic [30:0] xs2_r, ys2_r;
  logic [4:0]  sh2_r, sh3_r;
  logic [61:0] xx3_r, yy3_r;
  logic [47:0] n3_r;
  logic [62:0] den4_r, den5_r;
  logic [63:0] num4_r, num5_r;
  logic [5:0]  r5_r;
  ratio_t      ratio_r;

  logic        neg0;
  logic [46:0] by0;
  logic [6:0]  bl1, bl5;
  logic [4:0]  s1;
  logic [5:0]  r5;
  logic [63:0] nsh, dsh;

  assign adv[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_comb begin
    neg0 = offset_y[YW-1];
    by0  = neg0 ? 47'(-offset_y) : 47'(offset_y);
    bl1  = bit_len64(64'(by0_r | 47'(bx0_r)));
    s1   = (bl1 > 7'd31) ? 5'(bl1 - 7'd31) : 5'd0;
    bl5  = bit_len64(num4_r | 64'(den4_r));
    r5   = (bl5 > 7'd30) ? 6'(bl5 - 7'd30) : 6'd0;
    nsh  = num5_r >> r5_r;
    dsh  = 64'(den5_r) >> r5_r;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg0_r <= neg0;
      by0_r  <= by0;
      bx0_r  <= {look_dist, 16'd0};
    end
    if (adv[1]) begin
      neg1_r <= neg0_r;
      bx1_r  <= bx0_r;
      by1_r  <= by0_r;
      s1_r   <= s1;
    end
    if (adv[2]) begin
      neg2_r <= neg1_r;
      xs2_r  <= 31'(bx1_r >> s1_r);
      ys2_r  <= 31'(by1_r >> s1_r);
      sh2_r  <= 5'd16 - s1_r;
    end
    if (adv[3]) begin
      neg3_r <= neg2_r;
      xx3_r  <= 62'(xs2_r) * 62'(xs2_r);
      yy3_r  <= 62'(ys2_r) * 62'(ys2_r);
      n3_r   <= 48'({wheelbase_len, 1'b0}) * 48'(ys2_r);
      sh3_r  <= sh2_r;
    end
    if (adv[4]) begin
      neg4_r <= neg3_r;
      den4_r <= 63'(xx3_r) + 63'(yy3_r);
      num4_r <= 64'(n3_r) << sh3_r;
    end
    if (adv[5]) begin
      neg5_r <= neg4_r;
      den5_r <= den4_r;
      num5_r <= num4_r;
      r5_r   <= r5;
    end
    if (adv[6]) begin
      ratio_r.num <= nsh[RatioW-1:0];
      ratio_r.den <= dsh[RatioW-1:0];
      ratio_r.neg <= neg5_r;
      ratio_r.go  <= |nsh;
    end
  end

  assign out_valid = v_r[NS-1];
  assign ratio     = ratio_r;

endmodule

/* rtl/ppss_cordic.sv */
`timescale 1ns / 1ps
module ppss_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ppss_pkg::ratio_t ratio,
  output logic             out_valid,
  input  logic             out_ready,
  output ppss_pkg::angle_t angle
);
  import ppss_pkg::*;

  localparam int unsigned NS = CordicSteps;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  logic signed [CxW-1:0] xc_r [NS];
  logic signed [CxW-1:0] yc_r [NS];
  logic signed [CzW-1:0] z_r  [NS];
  logic                  neg_r [NS];
  logic                  go_r  [NS];

  assign adv[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_in[k];
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [CxW-1:0] xi, yi, dx, dy;
    logic signed [CzW-1:0] zi, ai;
    logic                  ni, gi;

    if (i == 0) begin : g_first
      assign xi = $signed(CxW'(ratio.den));
      assign yi = $signed(CxW'(ratio.num));
      assign zi = '0;
      assign ni = ratio.neg;
      assign gi = ratio.go;
    end else begin : g_next
      assign xi = xc_r[i-1];
      assign yi = yc_r[i-1];
      assign zi = z_r[i-1];
      assign ni = neg_r[i-1];
      assign gi = go_r[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign ai = $signed(CzW'(AtanQ30[i]));

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        if (yi > 0) begin
          xc_r[i] <= xi + dx;
          yc_r[i] <= yi - dy;
          z_r[i]  <= zi + ai;
        end else begin
          xc_r[i] <= xi - dx;
          yc_r[i] <= yi + dy;
          z_r[i]  <= zi - ai;
        end
        neg_r[i] <= ni;
        go_r[i]  <= gi;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign angle.z   = z_r[NS-1];
  assign angle.neg = neg_r[NS-1];
  assign angle.go  = go_r[NS-1];

endmodule

/* rtl/ppss_post.sv */
`timescale 1ns / 1ps
module ppss_post (
  input  logic                clk,
  input  logic                rst_n,
  input  ppss_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppss_pkg::angle_t    angle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  wheel_angle,
  output logic [15:0]         speed_cmd
);
  import ppss_pkg::*;

  localparam int unsigned NS = 6;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  logic [31:0]        mag0_r;
  logic               sgn0_r, go0_r, sgn1_r, go1_r;
  logic [63:0]        prod1_r;
  logic signed [15:0] ang2_r, ang3_r, ang4_r, ang5_r;
  logic [29:0]        sq3_r;
  logic [53:0]        pf4_r;
  logic [15:0]        spd5_r;

  logic [31:0]        mag0;
  logic [63:0]        rnd2;
  logic [17:0]        m2;
  logic signed [18:0] sa2;
  logic signed [15:0] ang2;
  logic [14:0]        amag3;
  logic [54:0]        rnd5;
  logic [26:0]        pen5;
  logic [15:0]        top5, flo5, spd5;

  assign adv[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_comb begin
    mag0 = angle.z[CzW-1] ? 32'(-angle.z) : 32'(angle.z);
    rnd2 = prod1_r + 64'(64'd1 << 45);
    m2   = rnd2[63:46];
    sa2  = sgn1_r ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
    if (!go1_r)                   ang2 = '0;
    else if (sa2 > 19'(AngleMax)) ang2 = AngleMax;
    else if (sa2 < 19'(AngleMin)) ang2 = AngleMin;
    else                          ang2 = 16'(sa2);
    amag3 = ang2_r[15] ? 15'(-ang2_r) : 15'(ang2_r);
    rnd5  = 55'(pf4_r) + 55'(55'd1 << 27);
    pen5  = rnd5[54:28];
    top5  = {(cfg.mode_select ? cfg.wpt_max_speed : cfg.lane_max_speed), 8'd0};
    flo5  = {cfg.floor_speed, 8'd0};
    spd5  = (pen5 >= 27'(top5)) ? 16'd0 : top5 - pen5[15:0];
    if (spd5 < flo5) spd5 = flo5;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mag0_r <= mag0;
      sgn0_r <= angle.z[CzW-1] != angle.neg;
      go0_r  <= angle.go;
    end
    if (adv[1]) begin
      prod1_r <= 64'(mag0_r) * 64'(DegScale);
      sgn1_r  <= sgn0_r;
      go1_r   <= go0_r;
    end
    if (adv[2]) ang2_r <= ang2;
    if (adv[3]) begin
      ang3_r <= ang2_r;
      sq3_r  <= 30'(amag3) * 30'(amag3);
    end
    if (adv[4]) begin
      ang4_r <= ang3_r;
      pf4_r  <= 54'(sq3_r) * 54'(cfg.speed_gain);
    end
    if (adv[5]) begin
      ang5_r <= ang4_r;
      spd5_r <= spd5;
    end
  end

  assign out_valid    = v_r[NS-1];
  assign wheel_angle  = ang5_r;
  assign speed_cmd    = spd5_r;

endmodule

/* rtl/ppss_checker.sv */
`timescale 1ns / 1ps
`include "pure_pursuit_steering_speed_assert.svh"
module ppss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `PPSS_ASSERT_RST(a_rst_idle, !out_tvalid, "output valid right after reset")

  `PPSS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output word changed")

  `PPSS_ASSERT_IMP(a_angle_range, out_tvalid, ($signed(out_tdata[15:0]) <= 16'sd30720) && ($signed(out_tdata[15:0]) >= -16'sd31360), "wheel angle outside clamp range")

  `PPSS_ASSERT_IMP(a_straight_speed, out_tvalid && (out_tdata[15:0] == 16'd0), out_tdata[23:16] == 8'd0, "straight ahead speed carries a penalty")

endmodule

bind pure_pursuit_steering_speed ppss_checker u_ppss_checker (.*);

/* verif/pure_pursuit_steering_speed_test.sv */
`timescale 1ns / 1ps
module pure_pursuit_steering_speed_test;
  import ppss_pkg::*;

  localparam int Latency = 49;
  localparam longint CycleLimit = 400000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // coef_const, coef_linear, coef_square, coef_cube (32 bits each)
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // wheel_angle (16), speed_cmd (16)
  logic [31:0]  out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;

  pure_pursuit_steering_speed u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // predictor's copy of the register file
  cfg_t regs;

  // expected result words, oldest first
  logic [31:0] steer_q[$];
  int          error_count;
  longint      cycle_count;

  // idle and stall odds, percent
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // arctan(2^-i) in Q2.30, own copy
  longint atan_tab[30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  function automatic int msb_count(logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  // the magnitude is rounded before the sign returns, as in ppss_horner
  function automatic longint horner_step(longint acc, longint coef, longint x);
    longint m;
    longint r;
    m = (acc < 0) ? -acc : acc;
    m = (m * x + 128) >>> 8;
    r = ((acc < 0) ? -m : m) + coef;
    if (r > (64'sd1 <<< 46)) r = 64'sd1 <<< 46;
    if (r < -(64'sd1 <<< 46)) r = -(64'sd1 <<< 46);
    return r;
  endfunction

  function automatic logic [31:0] steer_predict(logic [127:0] coefs);
    longint x;
    longint y;
    logic       neg;
    logic [63:0] bx, by, num, den, mag, sq, pen, spd, flo;
    int s, r;
    longint xc, yc, z, dx, dy;
    longint ang;
    logic [127:0] prod;
    x = longint'(regs.look_dist);
    y = longint'($signed(coefs[127:96]));
    y = horner_step(y, longint'($signed(coefs[95:64])), x);
    y = horner_step(y, longint'($signed(coefs[63:32])), x);
    y = horner_step(y, longint'($signed(coefs[31:0])), x);
    ang = 0;
    neg = y < 0;
    by = neg ? -y : y;
    if (by != 0) begin
      bx = 64'(x) << 16;
      s = msb_count(bx > by ? bx : by) - 31;
      if (s < 0) s = 0;
      bx = bx >> s;
      by = by >> s;
      den = bx * bx + by * by;
      num = (64'd2 * regs.wheelbase_len * by) << (16 - s);
      r = msb_count(num > den ? num : den) - 30;
      if (r < 0) r = 0;
      num = num >> r;
      den = den >> r;
      if (num != 0) begin
        xc = den; yc = num; z = 0;
        for (int i = 0; i < 30; i++) begin
          dx = yc >>> i;
          dy = xc >>> i;
          if (yc > 0) begin
            xc += dx; yc -= dy; z += atan_tab[i];
          end else begin
            xc -= dx; yc += dy; z -= atan_tab[i];
          end
        end
        mag = (z < 0) ? -z : z;
        prod = 128'(mag) * 128'd2883791006 + (128'd1 << 45);
        mag = 64'(prod >> 46);
        ang = ((z < 0) != neg) ? -longint'(mag) : longint'(mag);
      end
    end
    if (ang > 30720) ang = 30720;
    if (ang < -31360) ang = -31360;
    mag = (ang < 0) ? -ang : ang;
    sq = mag * mag;
    pen = (sq * regs.speed_gain + (64'd1 << 27)) >> 28;
    spd = 64'(regs.mode_select ? regs.wpt_max_speed : regs.lane_max_speed) << 8;
    flo = 64'(regs.floor_speed) << 8;
    spd = (pen >= spd) ? 64'd0 : spd - pen;
    if (spd < flo) spd = flo;
    return {spd[15:0], ang[15:0]};
  endfunction

  // register write, block must be idle
  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOOKAHEAD:    regs.look_dist = val[15:0];
      REG_WHEELBASE:    regs.wheelbase_len = val[15:0];
      REG_SPEED_GAIN:   regs.speed_gain = val;
      REG_MODE:         regs.mode_select = val[0];
      REG_LANE_MAX:     regs.lane_max_speed = val[7:0];
      REG_WAYPOINT_MAX: regs.wpt_max_speed = val[7:0];
      REG_FLOOR:        regs.floor_speed = val[7:0];
      default: ;
    endcase
  endtask

  // send one word; caller is at a falling edge
  task automatic send_word(logic [127:0] coefs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= coefs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    steer_q.push_back(steer_predict(coefs));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  // wait for every result, then let the pipeline drain
  task automatic drain();
    end_burst();
    while (steer_q.size() != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65535)) - 32768);
      2: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      3: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  // realistic lane: any offset, often small higher terms, sometimes anything
  function automatic logic [127:0] rand_lane();
    logic [31:0] c0, c1, c2, c3;
    if ($urandom_range(3) == 0) return {$urandom, $urandom, $urandom, $urandom};
    c0 = rand_coef();
    c1 = ($urandom_range(1)) ? rand_coef() : 32'($signed($urandom_range(4096)) - 2048);
    c2 = ($urandom_range(1)) ? 32'($signed($urandom_range(1024)) - 512) : rand_coef();
    c3 = ($urandom_range(2) == 0) ? rand_coef() : 32'($signed($urandom_range(64)) - 32);
    return {c3, c2, c1, c0};
  endfunction

  // result checker and receiver stall
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    logic [31:0] want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (steer_q.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = steer_q.pop_front();
        if (out_tdata[15:0] !== want[15:0]) begin
          $display("%0t: wheel_angle expected %0d actual %0d", $time,
                   $signed(want[15:0]), $signed(out_tdata[15:0]));
          error_count++;
        end
        if (out_tdata[31:16] !== want[31:16]) begin
          $display("%0t: speed_cmd expected %0d actual %0d", $time,
                   want[31:16], out_tdata[31:16]);
          error_count++;
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // extremes, zero offset, huge offset, each sign
  task automatic test_directed();
    send_word('0);
    send_word({96'd0, 32'h7fffffff});
    send_word({96'd0, 32'h80000000});
    send_word({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    send_word({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
    send_word({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
    send_word({96'd0, 32'd16777216});
    send_word({96'd0, -32'sd16777216});
    send_word({64'd0, 32'd1677722, 32'd0});
    send_word({32'd1, 32'd0, 32'd0, 32'hffffffff});
    send_word({128{1'b1}});
    send_word({4{32'h55555555}});
    send_word({4{32'haaaaaaaa}});
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_word(rand_lane());
    drain();
  endtask

  // register setting with extremes, then a random burst
  task automatic test_settings(logic [15:0] look, logic [15:0] wb, logic [23:0] gain,
                               logic mode, logic [7:0] lmax, logic [7:0] wmax,
                               logic [7:0] flr, int count);
    write_reg(REG_LOOKAHEAD, 24'(look));
    write_reg(REG_WHEELBASE, 24'(wb));
    write_reg(REG_SPEED_GAIN, gain);
    write_reg(REG_MODE, 24'(mode));
    write_reg(REG_LANE_MAX, 24'(lmax));
    write_reg(REG_WAYPOINT_MAX, 24'(wmax));
    write_reg(REG_FLOOR, 24'(flr));
    send_word('0);
    send_word({96'd0, 32'h7fffffff});
    test_random(count);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LOOKAHEAD;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    regs = '{look_dist: 16'd1536, wheelbase_len: 16'd768, speed_gain: 24'd25166,
             mode_select: 1'b0, lane_max_speed: 8'd20, wpt_max_speed: 8'd20,
             floor_speed: 8'd5};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults, no idling
    test_directed();
    test_random(150);
    // sender idles
    send_idle_pct = 52;
    test_settings(16'd65535, 16'd65535, 24'hffffff, 1'b1, 8'd255, 8'd255, 8'd0, 120);
    // receiver stalls
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_settings(16'd1, 16'd1, 24'd0, 1'b0, 8'd0, 8'd200, 8'd255, 120);
    // both, light, then heavy, then neither
    send_idle_pct = 7;
    recv_stall_pct = 7;
    test_settings(16'd0, 16'd300, 24'd1000, 1'b1, 8'd30, 8'd3, 8'd10, 120);
    send_idle_pct = 52;
    recv_stall_pct = 52;
    test_settings(16'd3000, 16'd700, 24'd25166, 1'b0, 8'd40, 8'd60, 8'd5, 120);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_settings(16'($urandom), 16'($urandom), 24'($urandom), 1'b1,
                  8'($urandom), 8'($urandom), 8'($urandom), 100);
    // out-of-range index is ignored by the block
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data <= 24'hffffff;
    @(negedge clk);
    cfg_we <= 1'b0;
    test_random(20);

    if (error_count == 0 && steer_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ppss_pkg.sv
rtl/ppss_horner.sv
rtl/ppss_ratio.sv
rtl/ppss_cordic.sv
rtl/ppss_post.sv
rtl/pure_pursuit_steering_speed.sv
rtl/ppss_checker.sv
verif/pure_pursuit_steering_speed_test.sv
